[hdl/hckd_pkg.sv]
// types, constants and helpers shared by the chord key decoder
`default_nettype none
package hckd_pkg;

    localparam int KEY_W      = 10;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef logic [KEY_W-1:0] key_t;

    localparam logic [1:0] VAL_RELEASE = 2'd0;
    localparam logic [1:0] VAL_PRESS   = 2'd1;
    localparam logic [1:0] VAL_REPEAT  = 2'd2;

    localparam logic KIND_TUNE   = 1'b0;
    localparam logic KIND_BUTTON = 1'b1;

    localparam logic signed [1:0] STEP_NONE = 2'sd0;
    localparam logic signed [1:0] STEP_UP   = 2'sd1;
    localparam logic signed [1:0] STEP_DOWN = -2'sd1;

    localparam logic ACT_RELEASE = 1'b0;
    localparam logic ACT_PRESS   = 1'b1;

    localparam logic [2:0] REG_VOL_UP    = 3'd0;
    localparam logic [2:0] REG_VOL_DOWN  = 3'd1;
    localparam logic [2:0] REG_LEFT_CTRL = 3'd2;
    localparam logic [2:0] REG_RIGHT_CTRL = 3'd3;
    localparam logic [2:0] REG_PREV_SONG = 3'd4;

    typedef struct packed {
        key_t vol_up;
        key_t vol_down;
        key_t left_ctrl;
        key_t right_ctrl;
        key_t prev_song;
    } cfg_t;

    typedef struct packed {
        logic              kind;
        logic signed [1:0] step;
        key_t              code;
        logic              chord;
        logic              prev;
        logic              action;
    } res_t;

    typedef struct packed {
        logic [1:0] n;
        res_t       r1;
        res_t       r0;
    } job_t;

    function automatic res_t mk_tune(input logic signed [1:0] step);
        res_t r;
        r        = '0;
        r.kind   = KIND_TUNE;
        r.step   = step;
        return r;
    endfunction

    function automatic res_t mk_button(input key_t code, input logic chord,
                                       input logic prev, input logic action);
        res_t r;
        r        = '0;
        r.kind   = KIND_BUTTON;
        r.step   = STEP_NONE;
        r.code   = code;
        r.chord  = chord;
        r.prev   = prev;
        r.action = action;
        return r;
    endfunction

endpackage
`default_nettype wire

[hdl/hckd_front.sv]
// front end: classifies key events, keeps chord state, builds result jobs
`default_nettype none
module hckd_front
    import hckd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cfg_t       cfg,
    input  wire logic       in_fire,
    input  wire key_t       key_code,
    input  wire logic [1:0] key_value,
    output logic            push,
    output job_t            job
);

    logic ctrl_held_reg,   ctrl_held_next;
    logic chord_valid_reg, chord_valid_next;
    key_t chord_key_reg,   chord_key_next;
    logic prev_chord_reg,  prev_chord_next;
    logic swal_valid_reg,  swal_valid_next;
    key_t swal_key_reg,    swal_key_next;
    logic swal_prev_reg,   swal_prev_next;

    logic is_press, is_release, is_repeat, latched;

    assign is_press   = (key_value == VAL_PRESS);
    assign is_release = (key_value == VAL_RELEASE);
    assign is_repeat  = (key_value == VAL_REPEAT);
    assign latched    = swal_valid_reg && (swal_key_reg == key_code);

    always_comb begin
        ctrl_held_next   = ctrl_held_reg;
        chord_valid_next = chord_valid_reg;
        chord_key_next   = chord_key_reg;
        prev_chord_next  = prev_chord_reg;
        swal_valid_next  = swal_valid_reg;
        swal_key_next    = swal_key_reg;
        swal_prev_next   = swal_prev_reg;
        job              = '0;

        if (key_code == cfg.vol_up) begin
            if (is_press || is_repeat) begin
                job.n  = 2'd1;
                job.r0 = mk_tune(STEP_UP);
            end
        end else if (key_code == cfg.vol_down) begin
            if (is_press || is_repeat) begin
                job.n  = 2'd1;
                job.r0 = mk_tune(STEP_DOWN);
            end
        end else if (key_code == cfg.left_ctrl || key_code == cfg.right_ctrl) begin
            ctrl_held_next = !is_release;
            if (is_release) begin
                if (chord_valid_reg) begin
                    job.n  = 2'd1;
                    job.r0 = mk_button(chord_key_reg, 1'b1, prev_chord_reg, ACT_RELEASE);
                end
                chord_valid_next = 1'b0;
                chord_key_next   = '0;
                prev_chord_next  = 1'b0;
            end
        end else if (key_code == cfg.prev_song) begin
            if (ctrl_held_reg) begin
                if (is_press) begin
                    prev_chord_next = 1'b1;
                    swal_prev_next  = 1'b1;
                end else if (is_release) begin
                    swal_prev_next  = 1'b0;
                end
            end else if (swal_prev_reg && is_release) begin
                swal_prev_next = 1'b0;
            end else if (swal_prev_reg && is_repeat) begin
                swal_prev_next = swal_prev_reg;
            end else if (is_release || is_press) begin
                job.n  = 2'd1;
                job.r0 = mk_button(key_code, 1'b0, 1'b0, key_value[0]);
            end
        end else if (!ctrl_held_reg) begin
            if (latched && is_release) begin
                swal_valid_next = 1'b0;
                swal_key_next   = '0;
            end else if (latched && is_repeat) begin
                swal_valid_next = swal_valid_reg;
            end else if (is_release || is_press) begin
                job.n  = 2'd1;
                job.r0 = mk_button(key_code, 1'b0, 1'b0, key_value[0]);
            end
        end else if (is_press) begin
            chord_valid_next = 1'b1;
            chord_key_next   = key_code;
            swal_valid_next  = 1'b1;
            swal_key_next    = key_code;
            if (chord_valid_reg && chord_key_reg != key_code) begin
                job.n  = 2'd2;
                job.r0 = mk_button(chord_key_reg, 1'b1, prev_chord_reg, ACT_RELEASE);
                job.r1 = mk_button(key_code, 1'b1, prev_chord_reg, ACT_PRESS);
            end else begin
                job.n  = 2'd1;
                job.r0 = mk_button(key_code, 1'b1, prev_chord_reg, ACT_PRESS);
            end
        end else if (is_release) begin
            if (chord_valid_reg && chord_key_reg == key_code) begin
                job.n            = 2'd1;
                job.r0           = mk_button(key_code, 1'b1, prev_chord_reg, ACT_RELEASE);
                chord_valid_next = 1'b0;
                chord_key_next   = '0;
                prev_chord_next  = 1'b0;
            end
            if (latched) begin
                swal_valid_next = 1'b0;
                swal_key_next   = '0;
            end
        end
    end

    assign push = in_fire && (job.n != 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_held_reg   <= 1'b0;
            chord_valid_reg <= 1'b0;
            chord_key_reg   <= '0;
            prev_chord_reg  <= 1'b0;
            swal_valid_reg  <= 1'b0;
            swal_key_reg    <= '0;
            swal_prev_reg   <= 1'b0;
        end else if (in_fire) begin
            ctrl_held_reg   <= ctrl_held_next;
            chord_valid_reg <= chord_valid_next;
            chord_key_reg   <= chord_key_next;
            prev_chord_reg  <= prev_chord_next;
            swal_valid_reg  <= swal_valid_next;
            swal_key_reg    <= swal_key_next;
            swal_prev_reg   <= swal_prev_next;
        end
    end

    a_chord_needs_ctrl: assert property (@(posedge aclk) disable iff (!aresetn)
        chord_valid_reg |-> ctrl_held_reg)
        else $error("chord key tracked without ctrl held");

    a_swallow_key_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !swal_valid_reg |-> (swal_key_reg == '0))
        else $error("swallow key left over after disarm");

    a_job_count: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (job.n == 2'd1 || job.n == 2'd2))
        else $error("bad result count in job");

endmodule
`default_nettype wire

[hdl/hckd_queue.sv]
// short job queue between front and back end
`default_nettype none
module hckd_queue
    import hckd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire job_t push_job,
    output logic      ready,
    input  wire logic pop,
    output logic      head_valid,
    output job_t      head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign ready      = (count_reg != CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule
`default_nettype wire

[hdl/hckd_back.sv]
// back end: unrolls each job into one or two result beats behind an output register
`default_nettype none
module hckd_back
    import hckd_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic head_valid,
    input  wire job_t head_job,
    output logic      pop,
    output logic      out_valid,
    input  wire logic out_ready,
    output res_t      out_res,
    output logic      out_last
);

    logic idx_reg;
    logic valid_reg;
    res_t res_reg;
    logic last_reg;
    logic load, is_last;

    assign load    = head_valid && (!valid_reg || out_ready);
    assign is_last = idx_reg || (head_job.n == 2'd1);
    assign pop     = load && is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 1'b0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg   <= !is_last;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg  <= idx_reg ? head_job.r1 : head_job.r0;
            last_reg <= is_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;
    assign out_last  = last_reg;

    a_second_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg |-> head_valid)
        else $error("second result pending without a queued job");

    a_second_needs_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg |-> (head_job.n == 2'd2))
        else $error("second result pending on a single-result job");

    a_tune_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && res_reg.kind == KIND_TUNE) |->
            (res_reg.code == '0 && !res_reg.chord && !res_reg.action))
        else $error("tune step carries button fields");

endmodule
`default_nettype wire

[hdl/hid_chord_key_decoder_core.sv]
// top level of the chord key decoder: config registers, front end, queue, back end
//
// s_ channel: one beat per key event, s_tdata = key_code[9:0], key_value[11:10].
// m_ channel: one beat per decoded event; an input beat gives zero, one or two
//   result beats, m_tlast marks the last one belonging to that input.
//   m_tuser = event_kind (0 tune step, 1 button); m_tdata holds tune_step,
//   button_code, is_chord, with_prev_song and button_action.
// apb port: five 10-bit key code registers at byte addresses 0,4,8,12,16
//   (volume up, volume down, left ctrl, right ctrl, previous song);
//   pready is tied high. Write only while the block is idle.
// The job of an accepted input beat enters the queue at the accepting edge; the queue
//   head then loads the output register, which offers the first result beat.
// Throughput: one input beat per cycle while each gives at most one result and
//   m_tready stays high; a two-result input keeps its job at the queue head until
//   both result beats are loaded, the queue absorbs the slip. The back end issues
//   one result beat per cycle while m_tready is high.
// Reset clears chord state, the queue and the output register and reloads
//   the default key codes. When m_tready is low the output beat is held and
//   the queue fills; s_tready drops once QUEUE_DEPTH jobs are waiting.
`default_nettype none
module hid_chord_key_decoder_core
    import hckd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,  // key_code[9:0], key_value[11:10]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [15:0]                m_tdata,  // tune_step[1:0], button_code[11:2],
                                                 // is_chord[12], with_prev_song[13],
                                                 // button_action[14]
    output logic                       m_tuser,  // event_kind
    output logic                       m_tlast,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    cfg_t       cfg_reg;
    logic       cfg_wr;
    logic [2:0] reg_idx;
    logic       in_fire, push, pop, q_ready, head_valid;
    job_t       job, head_job;
    res_t       out_res;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.vol_up     <= KEY_W'(115);
            cfg_reg.vol_down   <= KEY_W'(114);
            cfg_reg.left_ctrl  <= KEY_W'(29);
            cfg_reg.right_ctrl <= KEY_W'(97);
            cfg_reg.prev_song  <= KEY_W'(165);
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_VOL_UP:     cfg_reg.vol_up     <= pwdata[KEY_W-1:0];
                REG_VOL_DOWN:   cfg_reg.vol_down   <= pwdata[KEY_W-1:0];
                REG_LEFT_CTRL:  cfg_reg.left_ctrl  <= pwdata[KEY_W-1:0];
                REG_RIGHT_CTRL: cfg_reg.right_ctrl <= pwdata[KEY_W-1:0];
                REG_PREV_SONG:  cfg_reg.prev_song  <= pwdata[KEY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_VOL_UP:     prdata = APB_DATA_W'(cfg_reg.vol_up);
            REG_VOL_DOWN:   prdata = APB_DATA_W'(cfg_reg.vol_down);
            REG_LEFT_CTRL:  prdata = APB_DATA_W'(cfg_reg.left_ctrl);
            REG_RIGHT_CTRL: prdata = APB_DATA_W'(cfg_reg.right_ctrl);
            REG_PREV_SONG:  prdata = APB_DATA_W'(cfg_reg.prev_song);
            default:        prdata = '0;
        endcase
    end

    assign s_tready = q_ready;
    assign in_fire  = s_tvalid && q_ready;

    hckd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_fire   (in_fire),
        .key_code  (s_tdata[9:0]),
        .key_value (s_tdata[11:10]),
        .push      (push),
        .job       (job)
    );

    hckd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (job),
        .ready      (q_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    hckd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (out_res),
        .out_last   (m_tlast)
    );

    assign m_tuser = out_res.kind;
    assign m_tdata = {1'b0, out_res.action, out_res.prev, out_res.chord,
                      out_res.code, out_res.step};

endmodule
`default_nettype wire

[test/tb_top.sv]
// self-checking testbench for the hid chord key decoder core
`timescale 1ns / 1ps
module tb_top;
    import hckd_pkg::*;

    localparam int   STALL_LEN      = 250;
    localparam int   DRAIN_CYCLES   = 8;
    localparam int   WATCHDOG_LIMIT = 3000;
    localparam key_t RST_VOL_UP     = 10'd115;
    localparam key_t RST_VOL_DOWN   = 10'd114;
    localparam key_t RST_LEFT_CTRL  = 10'd29;
    localparam key_t RST_RIGHT_CTRL = 10'd97;
    localparam key_t RST_PREV_SONG  = 10'd165;

    typedef struct packed {
        key_t       code;
        logic [1:0] val;
    } key_stroke_t;

    typedef struct packed {
        logic last;
        res_t ev;
    } decoded_beat_t;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata  = '0;  // key_code[9:0], key_value[11:10]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;        // tune_step[1:0], button_code[11:2], is_chord[12],
                                           // with_prev_song[13], button_action[14]
    logic                  m_tuser;        // event_kind
    logic                  m_tlast;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    hid_chord_key_decoder_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // key codes as programmed
    key_t cfg_vol_up     = RST_VOL_UP;
    key_t cfg_vol_down   = RST_VOL_DOWN;
    key_t cfg_left_ctrl  = RST_LEFT_CTRL;
    key_t cfg_right_ctrl = RST_RIGHT_CTRL;
    key_t cfg_prev_song  = RST_PREV_SONG;

    // decoder state
    logic ctrl_down    = 1'b0;
    logic chord_active = 1'b0;
    key_t chord_code   = '0;
    logic chord_prev   = 1'b0;
    logic mute_valid   = 1'b0;
    key_t mute_code    = '0;
    logic mute_prev    = 1'b0;

    key_stroke_t   stroke_backlog[$];
    decoded_beat_t predicted_events[$];
    int            strokes_queued = 0;
    int            error_count    = 0;
    int            quiet_cycles   = 0;
    int            send_idle_pct  = 30;
    int            recv_idle_pct  = 72;
    logic          stall_req      = 1'b0;
    logic          stall_done     = 1'b0;
    int            stall_count    = 0;
    key_stroke_t   next_stroke;
    decoded_beat_t want;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void decode_key_event(input key_t code, input logic [1:0] val);
        res_t outs[$];
        logic latched;
        if (code == cfg_vol_up) begin
            if (val == VAL_PRESS || val == VAL_REPEAT)
                outs.insert(outs.size(), res_t'{kind: KIND_TUNE, step: STEP_UP, code: '0,
                                                chord: 1'b0, prev: 1'b0, action: 1'b0});
        end else if (code == cfg_vol_down) begin
            if (val == VAL_PRESS || val == VAL_REPEAT)
                outs.insert(outs.size(), res_t'{kind: KIND_TUNE, step: STEP_DOWN, code: '0,
                                                chord: 1'b0, prev: 1'b0, action: 1'b0});
        end else if (code == cfg_left_ctrl || code == cfg_right_ctrl) begin
            ctrl_down = (val != VAL_RELEASE);
            if (!ctrl_down) begin
                // forced release of a chord key still held
                if (chord_active)
                    outs.insert(outs.size(), res_t'{kind: KIND_BUTTON, step: STEP_NONE,
                                                    code: chord_code, chord: 1'b1,
                                                    prev: chord_prev, action: ACT_RELEASE});
                chord_active = 1'b0;
                chord_code   = '0;
                chord_prev   = 1'b0;
            end
        end else if (code == cfg_prev_song) begin
            if (ctrl_down) begin
                if (val == VAL_PRESS) begin
                    chord_prev = 1'b1;
                    mute_prev  = 1'b1;
                end else if (val == VAL_RELEASE) begin
                    mute_prev = 1'b0;
                end
            end else if (mute_prev && val == VAL_RELEASE) begin
                mute_prev = 1'b0;
            end else if (mute_prev && val == VAL_REPEAT) begin
                // held through the window
            end else if (val == VAL_RELEASE || val == VAL_PRESS) begin
                outs.insert(outs.size(), res_t'{kind: KIND_BUTTON, step: STEP_NONE,
                                                code: code, chord: 1'b0, prev: 1'b0,
                                                action: (val == VAL_PRESS) ?
                                                        ACT_PRESS : ACT_RELEASE});
            end
        end else if (!ctrl_down) begin
            latched = mute_valid && mute_code == code;
            if (latched && val == VAL_RELEASE) begin
                mute_valid = 1'b0;
                mute_code  = '0;
            end else if (latched && val == VAL_REPEAT) begin
                // held through the window
            end else if (val == VAL_RELEASE || val == VAL_PRESS) begin
                outs.insert(outs.size(), res_t'{kind: KIND_BUTTON, step: STEP_NONE,
                                                code: code, chord: 1'b0, prev: 1'b0,
                                                action: (val == VAL_PRESS) ?
                                                        ACT_PRESS : ACT_RELEASE});
            end
        end else if (val == VAL_PRESS) begin
            if (chord_active && chord_code != code)
                outs.insert(outs.size(), res_t'{kind: KIND_BUTTON, step: STEP_NONE,
                                                code: chord_code, chord: 1'b1,
                                                prev: chord_prev, action: ACT_RELEASE});
            chord_active = 1'b1;
            chord_code   = code;
            mute_valid   = 1'b1;
            mute_code    = code;
            outs.insert(outs.size(), res_t'{kind: KIND_BUTTON, step: STEP_NONE, code: code,
                                            chord: 1'b1, prev: chord_prev,
                                            action: ACT_PRESS});
        end else if (val == VAL_RELEASE) begin
            if (chord_active && chord_code == code) begin
                outs.insert(outs.size(), res_t'{kind: KIND_BUTTON, step: STEP_NONE,
                                                code: code, chord: 1'b1, prev: chord_prev,
                                                action: ACT_RELEASE});
                chord_active = 1'b0;
                chord_code   = '0;
                chord_prev   = 1'b0;
            end
            if (mute_valid && mute_code == code) begin
                mute_valid = 1'b0;
                mute_code  = '0;
            end
        end
        foreach (outs[i])
            predicted_events.insert(predicted_events.size(),
                                    decoded_beat_t'{last: (i == outs.size() - 1),
                                                    ev: outs[i]});
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (stroke_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_stroke = stroke_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {4'b0, next_stroke.val, next_stroke.code};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver with a long hold-off on request
    always @(posedge aclk) begin
        if (stall_req) begin
            if (stall_count < STALL_LEN) begin
                stall_count <= stall_count + 1;
                m_tready    <= 1'b0;
            end else begin
                stall_done <= 1'b1;
                m_tready   <= ($urandom_range(99) >= recv_idle_pct);
            end
        end else begin
            stall_count <= 0;
            stall_done  <= 1'b0;
            m_tready    <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: predict on each input beat, check each result beat
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                decode_key_event(s_tdata[9:0], s_tdata[11:10]);
            if (m_tvalid && m_tready) begin
                if (predicted_events.size() == 0) begin
                    $error("unexpected result beat: tuser %0d tdata %h", m_tuser, m_tdata);
                    error_count++;
                end else begin
                    want = predicted_events.pop_front();
                    check_field("event_kind", want.ev.kind, m_tuser);
                    check_field("tune_step", $unsigned(want.ev.step), m_tdata[1:0]);
                    check_field("button_code", want.ev.code, m_tdata[11:2]);
                    check_field("is_chord", want.ev.chord, m_tdata[12]);
                    check_field("with_prev_song", want.ev.prev, m_tdata[13]);
                    check_field("button_action", want.ev.action, m_tdata[14]);
                    check_field("last_of_run", want.last, m_tlast);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_stroke(input key_t code, input logic [1:0] val);
        stroke_backlog.insert(stroke_backlog.size(), key_stroke_t'{code: code, val: val});
        strokes_queued++;
    endtask

    function automatic key_t chord_candidate();
        if ($urandom_range(2) != 0)
            return key_t'(30 + $urandom_range(3));
        return key_t'($urandom_range(1023));
    endfunction

    function automatic key_t pick_code();
        case ($urandom_range(9))
            0:       return cfg_vol_up;
            1:       return cfg_vol_down;
            2:       return cfg_left_ctrl;
            3:       return cfg_right_ctrl;
            4:       return cfg_prev_song;
            5, 6:    return chord_candidate();
            default: return key_t'($urandom_range(1023));
        endcase
    endfunction

    task automatic queue_chord_sequence();
        key_t ctl;
        key_t first_key;
        key_t second_key;
        logic with_prev;
        ctl        = $urandom_range(1) ? cfg_left_ctrl : cfg_right_ctrl;
        with_prev  = ($urandom_range(2) == 0);
        first_key  = chord_candidate();
        second_key = chord_candidate();
        add_stroke(ctl, VAL_PRESS);
        if ($urandom_range(3) == 0)
            add_stroke(ctl, VAL_REPEAT);
        if (with_prev)
            add_stroke(cfg_prev_song, VAL_PRESS);
        add_stroke(first_key, VAL_PRESS);
        repeat ($urandom_range(2)) add_stroke(first_key, VAL_REPEAT);
        if ($urandom_range(2) == 0) begin
            add_stroke(second_key, VAL_PRESS);
            if ($urandom_range(1))
                add_stroke(first_key, VAL_RELEASE);
            first_key = second_key;
        end
        if ($urandom_range(1))
            add_stroke(first_key, VAL_RELEASE);
        if (with_prev && $urandom_range(1))
            add_stroke(cfg_prev_song, VAL_RELEASE);
        add_stroke(ctl, VAL_RELEASE);
        if ($urandom_range(2) == 0)
            add_stroke(first_key, VAL_REPEAT);
        add_stroke(first_key, VAL_RELEASE);
        if (with_prev)
            add_stroke(cfg_prev_song, $urandom_range(1) ? VAL_RELEASE : VAL_REPEAT);
        if ($urandom_range(4) == 0) begin
            add_stroke(first_key, VAL_PRESS);
            add_stroke(first_key, VAL_RELEASE);
        end
    endtask

    task automatic add_random_strokes(input int n);
        int target;
        int pick;
        target = strokes_queued + n;
        while (strokes_queued < target) begin
            pick = $urandom_range(9);
            if (pick < 6) begin
                queue_chord_sequence();
            end else if (pick < 8) begin
                repeat (1 + $urandom_range(3))
                    add_stroke($urandom_range(1) ? cfg_vol_up : cfg_vol_down,
                               2'($urandom_range(2)));
            end else begin
                add_stroke(pick_code(), 2'($urandom_range(3)));
            end
        end
    endtask

    task automatic settle();
        while (stroke_backlog.size() != 0 || s_tvalid || predicted_events.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input key_t value);
        logic [APB_DATA_W-1:0] word;
        word             = $urandom();
        word[KEY_W-1:0]  = value;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_VOL_UP:     cfg_vol_up     = value;
            REG_VOL_DOWN:   cfg_vol_down   = value;
            REG_LEFT_CTRL:  cfg_left_ctrl  = value;
            REG_RIGHT_CTRL: cfg_right_ctrl = value;
            REG_PREV_SONG:  cfg_prev_song  = value;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic program_codes(input key_t up, input key_t down, input key_t left,
                                 input key_t right, input key_t prev);
        write_reg(REG_VOL_UP, up);
        write_reg(REG_VOL_DOWN, down);
        write_reg(REG_LEFT_CTRL, left);
        write_reg(REG_RIGHT_CTRL, right);
        write_reg(REG_PREV_SONG, prev);
    endtask

    task automatic hold_receiver();
        @(negedge aclk);
        stall_req <= 1'b1;
        @(negedge aclk);
        while (!stall_done) @(negedge aclk);
        stall_req <= 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed pass at reset codes
        add_stroke(10'd0, VAL_PRESS);
        add_stroke(10'd0, VAL_RELEASE);
        add_stroke(10'd1023, VAL_PRESS);
        add_stroke(10'd1023, 2'd3);
        add_stroke(10'd1023, VAL_REPEAT);
        add_stroke(10'd1023, VAL_RELEASE);
        add_stroke(RST_VOL_UP, VAL_PRESS);
        add_stroke(RST_VOL_UP, VAL_REPEAT);
        add_stroke(RST_VOL_UP, VAL_RELEASE);
        add_stroke(RST_VOL_DOWN, VAL_PRESS);
        add_stroke(RST_VOL_DOWN, 2'd3);
        add_stroke(RST_LEFT_CTRL, 2'd3);
        add_stroke(RST_PREV_SONG, VAL_PRESS);
        add_stroke(10'd40, VAL_PRESS);
        add_stroke(10'd40, VAL_REPEAT);
        add_stroke(10'd41, VAL_PRESS);
        add_stroke(10'd40, VAL_RELEASE);
        add_stroke(RST_RIGHT_CTRL, VAL_RELEASE);
        add_stroke(10'd41, VAL_REPEAT);
        add_stroke(10'd41, VAL_RELEASE);
        add_stroke(RST_PREV_SONG, VAL_REPEAT);
        add_stroke(RST_PREV_SONG, VAL_RELEASE);
        add_stroke(RST_PREV_SONG, VAL_PRESS);
        add_stroke(RST_PREV_SONG, VAL_RELEASE);
        add_stroke(RST_RIGHT_CTRL, VAL_PRESS);
        add_stroke(10'd50, VAL_PRESS);
        add_stroke(10'd50, VAL_RELEASE);
        add_stroke(RST_RIGHT_CTRL, VAL_RELEASE);
        settle();

        add_random_strokes(60);
        hold_receiver();
        add_random_strokes(290);
        settle();

        program_codes(10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        add_random_strokes(150);
        settle();

        send_idle_pct <= 72;
        recv_idle_pct <= 30;
        program_codes(10'd1023, 10'd0, 10'd1, 10'd1022, 10'd512);
        add_random_strokes(400);
        settle();

        // overlapping codes: left ctrl hidden by volume down, prev song by right ctrl
        program_codes(10'd5, 10'd6, 10'd6, 10'd8, 10'd8);
        add_random_strokes(250);
        settle();

        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        program_codes(key_t'($urandom_range(1023)), key_t'($urandom_range(1023)),
                      key_t'($urandom_range(1023)), key_t'($urandom_range(1023)),
                      key_t'($urandom_range(1023)));
        add_random_strokes(60);
        hold_receiver();
        add_random_strokes(190);
        settle();
        add_random_strokes(100);
        settle();

        program_codes(RST_VOL_UP, RST_VOL_DOWN, RST_LEFT_CTRL, RST_RIGHT_CTRL,
                      RST_PREV_SONG);
        add_random_strokes(250);
        settle();

        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

[filelist.f]
hdl/hckd_pkg.sv
hdl/hckd_front.sv
hdl/hckd_queue.sv
hdl/hckd_back.sv
hdl/hid_chord_key_decoder_core.sv
test/tb_top.sv
